[design/sts_pkg.sv]
// Shared types, constants and helpers for the source text token scanner.
// No dependencies; imported by every module of the block.
package sts_pkg;

  localparam int TOKEN_LEN   = 64;
  localparam int TOK_LEN_W   = $clog2(TOKEN_LEN + 2);
  localparam int OFFSET_W    = 24;
  localparam int VALUE_W     = 32;
  localparam int KIND_W      = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int ZCNT_W      = 3;
  localparam int OUT_DATA_W  = 48;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_OPEN   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CLOSE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STRING = 3'd2;
  localparam logic [KIND_W-1:0] KIND_IDENT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NUMBER = 3'd4;
  localparam logic [KIND_W-1:0] KIND_END    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_STRB   = 3'd6;
  localparam logic [KIND_W-1:0] KIND_IDCHAR = 3'd7;

  // Characters of interest
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_EOF    = 8'h1A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LT     = 8'h74;

  // (c - 30) mod 256
  localparam logic [7:0] STR_BIAS  = 8'd226;
  localparam logic [7:0] STR_SPACE = 8'd2;

  // One entry per accepted character: everything the back end must emit.
  // Emission order: a token, space byte, string byte, zero bytes, b token.
  typedef struct packed {
    logic               a_valid;
    logic [KIND_W-1:0]  a_kind;
    logic [VALUE_W-1:0] a_value;
    logic               a_trunc;
    logic               sp;
    logic               str_valid;
    logic [7:0]         str_code;
    logic [ZCNT_W-1:0]  zeros;
    logic               b_valid;
    logic [KIND_W-1:0]  b_kind;
    logic [7:0]         b_byte;
    logic [VALUE_W-1:0] b_value;
  } cmd_t;

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  function automatic logic [7:0] str_enc(input logic [7:0] c);
    return c + STR_BIAS;
  endfunction

endpackage

[design/source_text_token_scanner.sv]
// Top level of the source text token scanner: front end, command queue
// and back end. Depends on sts_pkg, sts_front, sts_queue, sts_back.
//
// Takes one source character per beat and streams out token events. A
// character is accepted every cycle as long as the four-entry command queue
// has room; each character that produces results becomes one queue entry,
// and the back end turns that entry into result beats at one beat per cycle
// unless m_tready stalls it, through a registered output stage. A character
// that yields n results (n from 0 to 6, e.g. a closing quote with padding,
// or end of input inside a string) therefore occupies the result port for n
// beats, and the queue absorbs short bursts so the input keeps flowing. Each
// command passes the queue entry, the command registers and the output register.
// Results carry tlast on the final beat belonging to one input character.
// The word offset reported by a string token is loaded by a cfg write and
// then advances by one per completed 4-byte string word, saturating at
// 0xFFFFFF. After an end marker (tlast on input, or byte 0x1A) all further
// characters are taken and ignored until reset. cfg_ready is always high;
// write only while no character is in flight.
module source_text_token_scanner (
  input  logic                          clk,
  input  logic                          rst,
  // input character beats
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] ch
  input  logic                          s_tlast,   // at_end
  // result beats
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sts_pkg::OUT_DATA_W-1:0] m_tdata,  // [7:0] data_byte, [39:8] value,
                                                    // [40] truncated, rest zero
  output logic [sts_pkg::KIND_W-1:0]    m_tuser,   // [2:0] kind
  output logic                          m_tlast,   // last
  // start_offset register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sts_pkg::OFFSET_W-1:0]  cfg_data
);
  import sts_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_push, q_pop, q_not_full, q_not_empty;

  assign cfg_ready = 1'b1;

  sts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .q_ready   (q_not_full),
    .q_push    (q_push),
    .q_cmd     (front_cmd)
  );

  sts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (front_cmd),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_cmd)
  );

  sts_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_not_empty),
    .q_head   (head_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

[design/sts_front.sv]
// Front end: accepts characters, tracks scanner state, builds one command
// per character that produces results for the back end. Depends on sts_pkg.
module sts_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,
  input  logic                        s_tlast,
  input  logic                        cfg_valid,
  input  logic [sts_pkg::OFFSET_W-1:0] cfg_data,
  input  logic                        q_ready,
  output logic                        q_push,
  output sts_pkg::cmd_t               q_cmd
);
  import sts_pkg::*;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_COMMENT = 3'd1;
  localparam logic [2:0] MODE_STRING  = 3'd2;
  localparam logic [2:0] MODE_ESCAPE  = 3'd3;
  localparam logic [2:0] MODE_RUN     = 3'd4;

  localparam logic [OFFSET_W-1:0]  OFFSET_MAX = '1;
  localparam logic [VALUE_W-1:0]   MAG_MAX    = 32'h8000_0000;
  localparam logic [VALUE_W-1:0]   POS_MAX    = 32'h7FFF_FFFF;
  localparam logic [TOK_LEN_W-1:0] LEN_LIMIT  = TOK_LEN_W'(TOKEN_LEN);
  localparam logic [TOK_LEN_W-1:0] LEN_OVER   = TOK_LEN_W'(TOKEN_LEN + 1);

  logic [2:0]           mode, mode_next;
  logic                 pending_space, pending_space_next;
  logic [1:0]           byte_phase, byte_phase_next;
  logic [OFFSET_W-1:0]  msg_off, msg_off_next;
  logic [TOK_LEN_W-1:0] tok_len, tok_len_next;
  logic [VALUE_W-1:0]   acc, acc_next;
  logic                 neg, neg_next;
  logic                 digits, digits_next;
  logic                 numeric, numeric_next;
  logic                 ended, ended_next;

  logic accept;

  always_comb begin
    logic [7:0]           c;
    logic [7:0]           put_c;
    logic [7:0]           lc;
    logic                 end_in;
    logic                 fin_run;
    logic                 fin_str;
    logic                 put_char;
    logic                 idle;
    logic                 run_step;
    logic                 first;
    logic                 sp;
    logic [1:0]           p1;
    logic [ZCNT_W-1:0]    nbytes;
    logic [3:0]           psum;
    logic [OFFSET_W:0]    off_sum;
    logic [TOK_LEN_W-1:0] base_len;
    logic [VALUE_W-1:0]   base_acc;
    logic [35:0]          prod;

    c        = s_tdata;
    end_in   = s_tlast || c == CH_EOF;
    fin_run  = 1'b0;
    fin_str  = 1'b0;
    put_char = 1'b0;
    put_c    = c;
    idle     = 1'b0;
    run_step = 1'b0;
    first    = 1'b0;

    q_cmd               = '0;
    mode_next           = mode;
    pending_space_next  = pending_space;
    byte_phase_next     = byte_phase;
    tok_len_next        = tok_len;
    acc_next            = acc;
    neg_next            = neg;
    digits_next         = digits;
    numeric_next        = numeric;
    ended_next          = ended;

    if (!ended) begin
      if (end_in) begin
        if (mode == MODE_RUN) begin
          fin_run = 1'b1;
        end else if (mode == MODE_STRING || mode == MODE_ESCAPE) begin
          fin_str = 1'b1;
        end
        mode_next     = MODE_IDLE;
        ended_next    = 1'b1;
        q_cmd.b_valid = 1'b1;
        q_cmd.b_kind  = KIND_END;
      end else if (c == CH_CR || c == CH_NUL) begin
        // dropped everywhere
      end else begin
        case (mode)
          MODE_COMMENT: begin
            if (c == CH_LF) mode_next = MODE_IDLE;
          end
          MODE_STRING: begin
            if (c == CH_QUOTE) begin
              fin_str   = 1'b1;
              mode_next = MODE_IDLE;
            end else if (is_space(c)) begin
              pending_space_next = 1'b1;
            end else if (c == CH_BSLASH) begin
              mode_next = MODE_ESCAPE;
            end else begin
              put_char = 1'b1;
            end
          end
          MODE_ESCAPE: begin
            put_char  = 1'b1;
            if (c == CH_LN) begin
              put_c = CH_LF;
            end else if (c == CH_LT) begin
              put_c = CH_TAB;
            end
            mode_next = MODE_STRING;
          end
          MODE_RUN: begin
            if (is_space(c) || c == CH_LPAREN || c == CH_RPAREN || c == CH_QUOTE) begin
              fin_run   = 1'b1;
              idle      = 1'b1;
              mode_next = MODE_IDLE;
            end else begin
              run_step = 1'b1;
            end
          end
          default: begin
            idle      = 1'b1;
            mode_next = MODE_IDLE;
          end
        endcase
      end
    end

    // Closing token of an identifier/number run, from the state before this beat
    q_cmd.a_valid = fin_run;
    q_cmd.a_trunc = tok_len > LEN_LIMIT;
    if (numeric && digits) begin
      q_cmd.a_kind = KIND_NUMBER;
      if (neg) begin
        q_cmd.a_value = '0 - acc;
      end else begin
        q_cmd.a_value = (acc > POS_MAX) ? POS_MAX : acc;
      end
    end else begin
      q_cmd.a_kind  = KIND_IDENT;
      q_cmd.a_value = '0;
    end

    // String bytes and word offset bookkeeping
    sp = (fin_str || put_char) && pending_space;
    if (sp) pending_space_next = 1'b0;
    q_cmd.sp        = sp;
    q_cmd.str_valid = put_char;
    q_cmd.str_code  = str_enc(put_c);
    p1 = byte_phase + {1'b0, sp};
    q_cmd.zeros = fin_str ? (3'd4 - {1'b0, p1}) : '0;
    nbytes  = {2'b0, sp} + {2'b0, put_char} + q_cmd.zeros;
    psum    = {2'b0, byte_phase} + {1'b0, nbytes};
    byte_phase_next = psum[1:0];
    off_sum = {1'b0, msg_off} + {{(OFFSET_W-1){1'b0}}, psum[3:2]};
    msg_off_next = off_sum[OFFSET_W] ? OFFSET_MAX : off_sum[OFFSET_W-1:0];

    // Character seen between tokens
    if (idle) begin
      if (is_space(c)) begin
        // nothing
      end else if (c == CH_LPAREN) begin
        q_cmd.b_valid = 1'b1;
        q_cmd.b_kind  = KIND_OPEN;
      end else if (c == CH_RPAREN) begin
        q_cmd.b_valid = 1'b1;
        q_cmd.b_kind  = KIND_CLOSE;
      end else if (c == CH_QUOTE) begin
        q_cmd.b_valid      = 1'b1;
        q_cmd.b_kind       = KIND_STRING;
        q_cmd.b_value      = {{(VALUE_W-OFFSET_W){1'b0}}, msg_off};
        pending_space_next = 1'b0;
        byte_phase_next    = '0;
        mode_next          = MODE_STRING;
      end else if (c == CH_SEMI) begin
        mode_next = MODE_COMMENT;
      end else begin
        run_step  = 1'b1;
        first     = 1'b1;
        mode_next = MODE_RUN;
      end
    end

    // One character of a run
    base_len = first ? '0 : tok_len;
    base_acc = first ? '0 : acc;
    lc   = (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c;
    prod = {1'b0, base_acc, 3'b0} + {3'b0, base_acc, 1'b0} + {28'b0, c - CH_0};
    if (run_step) begin
      tok_len_next = LEN_OVER;
      if (base_len < LEN_LIMIT) begin
        q_cmd.b_valid = 1'b1;
        q_cmd.b_kind  = KIND_IDCHAR;
        q_cmd.b_byte  = lc;
        tok_len_next  = base_len + 1'b1;
      end
      acc_next     = base_acc;
      neg_next     = first ? 1'b0 : neg;
      digits_next  = first ? 1'b0 : digits;
      numeric_next = first ? 1'b1 : numeric;
      if (first && (c == CH_PLUS || c == CH_MINUS)) begin
        neg_next = c == CH_MINUS;
      end else if (c >= CH_0 && c <= CH_9) begin
        acc_next    = (prod > {4'b0, MAG_MAX}) ? MAG_MAX : prod[VALUE_W-1:0];
        digits_next = 1'b1;
      end else begin
        numeric_next = 1'b0;
      end
    end
  end

  assign s_tready = q_ready;
  assign accept   = s_tvalid && s_tready;
  assign q_push   = accept && (q_cmd.a_valid || q_cmd.sp || q_cmd.str_valid ||
                               q_cmd.zeros != '0 || q_cmd.b_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      pending_space <= 1'b0;
      byte_phase    <= '0;
      msg_off       <= '0;
      tok_len       <= '0;
      acc           <= '0;
      neg           <= 1'b0;
      digits        <= 1'b0;
      numeric       <= 1'b1;
      ended         <= 1'b0;
    end else begin
      if (accept) begin
        mode          <= mode_next;
        pending_space <= pending_space_next;
        byte_phase    <= byte_phase_next;
        tok_len       <= tok_len_next;
        acc           <= acc_next;
        neg           <= neg_next;
        digits        <= digits_next;
        numeric       <= numeric_next;
        ended         <= ended_next;
      end
      // a register write takes precedence over the running offset
      if (cfg_valid) begin
        msg_off <= cfg_data;
      end else if (accept) begin
        msg_off <= msg_off_next;
      end
    end
  end

endmodule

[design/sts_queue.sv]
// Short command queue between front and back end.
// Depends on sts_pkg for cmd_t and the depth constants.
module sts_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sts_pkg::cmd_t push_cmd,
  output logic          not_full,
  input  logic          pop,
  output logic          not_empty,
  output sts_pkg::cmd_t head
);
  import sts_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign not_full  = count != QCNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/sts_back.sv]
// Back end: expands each command into result beats, one per cycle unless
// the output stalls, into the output register. Depends on sts_pkg.
module sts_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  sts_pkg::cmd_t                 q_head,
  output logic                          q_pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sts_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [sts_pkg::KIND_W-1:0]    m_tuser,
  output logic                          m_tlast
);
  import sts_pkg::*;

  cmd_t              cmd;
  logic              a_pend, sp_pend, str_pend, b_pend;
  logic [ZCNT_W-1:0] zcnt;

  logic              busy, emit, rem_any, load;
  logic              a_pend_next, sp_pend_next, str_pend_next, b_pend_next;
  logic [ZCNT_W-1:0] zcnt_next;
  logic [KIND_W-1:0] o_kind;
  logic [7:0]        o_byte;
  logic [VALUE_W-1:0] o_value;
  logic              o_trunc;

  assign busy = a_pend || sp_pend || str_pend || zcnt != '0 || b_pend;
  assign emit = busy && (!m_tvalid || m_tready);

  // Pick the first pending item in emission order
  always_comb begin
    a_pend_next   = a_pend;
    sp_pend_next  = sp_pend;
    str_pend_next = str_pend;
    zcnt_next     = zcnt;
    b_pend_next   = b_pend;
    o_kind        = cmd.b_kind;
    o_byte        = cmd.b_byte;
    o_value       = cmd.b_value;
    o_trunc       = 1'b0;
    if (a_pend) begin
      a_pend_next = 1'b0;
      o_kind      = cmd.a_kind;
      o_byte      = '0;
      o_value     = cmd.a_value;
      o_trunc     = cmd.a_trunc;
    end else if (sp_pend) begin
      sp_pend_next = 1'b0;
      o_kind       = KIND_STRB;
      o_byte       = STR_SPACE;
      o_value      = '0;
    end else if (str_pend) begin
      str_pend_next = 1'b0;
      o_kind        = KIND_STRB;
      o_byte        = cmd.str_code;
      o_value       = '0;
    end else if (zcnt != '0) begin
      zcnt_next = zcnt - 1'b1;
      o_kind    = KIND_STRB;
      o_byte    = str_enc(CH_NUL);
      o_value   = '0;
    end else begin
      b_pend_next = 1'b0;
    end
    rem_any = a_pend_next || sp_pend_next || str_pend_next || zcnt_next != '0 ||
              b_pend_next;
  end

  assign load  = q_valid && (!busy || (emit && !rem_any));
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (load) cmd <= q_head;
    if (emit) begin
      m_tdata <= {{(OUT_DATA_W-VALUE_W-9){1'b0}}, o_trunc, o_value, o_byte};
      m_tuser <= o_kind;
      m_tlast <= !rem_any;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_pend   <= 1'b0;
      sp_pend  <= 1'b0;
      str_pend <= 1'b0;
      zcnt     <= '0;
      b_pend   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        a_pend   <= q_head.a_valid;
        sp_pend  <= q_head.sp;
        str_pend <= q_head.str_valid;
        zcnt     <= q_head.zeros;
        b_pend   <= q_head.b_valid;
      end else if (emit) begin
        a_pend   <= a_pend_next;
        sp_pend  <= sp_pend_next;
        str_pend <= str_pend_next;
        zcnt     <= zcnt_next;
        b_pend   <= b_pend_next;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[test/tb.sv]
// Self-checking testbench for source_text_token_scanner: streams source text in,
// predicts every token beat and compares what comes out.
// Depends on sts_pkg and the source_text_token_scanner RTL.
`timescale 1ns / 100ps

module tb;
  import sts_pkg::*;

  localparam int STALL_LIMIT  = 4000;  // cycles without any beat before giving up
  localparam int DRAIN_CYCLES = 12;    // queue depth plus pipeline, with margin
  localparam int RANDOM_ITEMS = 120;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_COMMENT, SCAN_STRING, SCAN_ESCAPE, SCAN_RUN
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       at_end;
  } src_char_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [7:0]         data_byte;
    logic [VALUE_W-1:0] value;
    logic               truncated;
    logic               last;
  } token_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = 8'h00;   // [7:0] ch
  logic                  s_tlast = 1'b0;    // [0] at_end
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;           // [7:0] data_byte, [39:8] value, [40] truncated
  logic [KIND_W-1:0]     m_tuser;           // [2:0] kind
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [OFFSET_W-1:0]   cfg_data = '0;

  source_text_token_scanner dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // Characters waiting to be offered, and token beats waiting to be seen.
  src_char_t   pending_chars[$];
  token_beat_t pending_tokens[$];
  token_beat_t step_beats[$];     // beats caused by the character being scanned

  // Pacing knobs, changed only between phases.
  bit src_paced  = 1'b0;
  bit sink_paced = 1'b0;

  int mismatches = 0;

  // ---------------------------------------------------------------------------
  // Scanner shadow state. Reset is applied once, so the declared initial
  // values stand in for the reset values.
  // ---------------------------------------------------------------------------
  scan_mode_t          mode       = SCAN_IDLE;
  logic                space_owed = 1'b0;   // collapsed whitespace not yet written
  logic [1:0]          word_phase = 2'd0;   // string bytes mod 4
  logic [OFFSET_W-1:0] msg_offset = '0;     // word offset the next string reports
  int                  run_len    = 0;
  logic [31:0]         magnitude  = '0;
  logic                minus      = 1'b0;
  logic                got_digit  = 1'b0;
  logic                numeric    = 1'b1;
  logic                ended      = 1'b0;

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  // At most seven beats per character; anything beyond is dropped.
  function automatic void add_beat(input logic [KIND_W-1:0] kind, input logic [7:0] b,
                                   input logic [31:0] v, input logic trunc);
    token_beat_t t;
    t.kind      = kind;
    t.data_byte = b;
    t.value     = v;
    t.truncated = trunc;
    t.last      = 1'b0;
    if (step_beats.size() < 7) step_beats.push_back(t);
  endfunction

  // String bytes go out biased down by 30; every fourth byte closes a word.
  function automatic void put_str_byte(input logic [7:0] c);
    add_beat(KIND_STRB, c - 8'd30, '0, 1'b0);
    word_phase = word_phase + 2'd1;
    if (word_phase == 2'd0 && msg_offset != {OFFSET_W{1'b1}}) msg_offset = msg_offset + 1'b1;
  endfunction

  function automatic void flush_space();
    if (space_owed) begin
      put_str_byte(CH_SPACE);
      space_owed = 1'b0;
    end
  endfunction

  function automatic void close_string();
    flush_space();
    put_str_byte(CH_NUL);
    while (word_phase != 2'd0) put_str_byte(CH_NUL);
    mode = SCAN_IDLE;
  endfunction

  function automatic void run_char(input logic [7:0] c, input logic first);
    logic [63:0] wide;
    if (run_len < TOKEN_LEN) begin
      add_beat(KIND_IDCHAR, (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c, '0, 1'b0);
      run_len++;
    end else begin
      run_len = TOKEN_LEN + 1;
    end
    if (first && (c == CH_PLUS || c == CH_MINUS)) begin
      minus = (c == CH_MINUS);
    end else if (c >= CH_0 && c <= CH_9) begin
      // magnitude clamps at 2^31 so the negative extreme stays exact
      wide = 64'(magnitude) * 10 + 64'(c - CH_0);
      magnitude = (wide > 64'h8000_0000) ? 32'h8000_0000 : wide[31:0];
      got_digit = 1'b1;
    end else begin
      numeric = 1'b0;
    end
  endfunction

  function automatic void close_run();
    logic        trunc;
    logic [31:0] v;
    trunc = (run_len > TOKEN_LEN);
    if (numeric && got_digit) begin
      if (minus) v = 32'd0 - magnitude;
      else v = (magnitude > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : magnitude;
      add_beat(KIND_NUMBER, '0, v, trunc);
    end else begin
      add_beat(KIND_IDENT, '0, '0, trunc);
    end
    mode = SCAN_IDLE;
  endfunction

  function automatic void idle_char(input logic [7:0] c);
    if (is_blank(c)) return;
    if (c == CH_LPAREN) begin
      add_beat(KIND_OPEN, '0, '0, 1'b0);
    end else if (c == CH_RPAREN) begin
      add_beat(KIND_CLOSE, '0, '0, 1'b0);
    end else if (c == CH_QUOTE) begin
      add_beat(KIND_STRING, '0, {8'd0, msg_offset}, 1'b0);
      space_owed = 1'b0;
      word_phase = 2'd0;
      mode       = SCAN_STRING;
    end else if (c == CH_SEMI) begin
      mode = SCAN_COMMENT;
    end else begin
      run_len   = 0;
      magnitude = '0;
      minus     = 1'b0;
      got_digit = 1'b0;
      numeric   = 1'b1;
      mode      = SCAN_RUN;
      run_char(c, 1'b1);
    end
  endfunction

  // Scan one accepted character; the beats it causes land in step_beats.
  function automatic void scan_char(input logic [7:0] c_in, input logic at_end);
    logic [7:0]  c;
    token_beat_t t;
    c = c_in;
    step_beats.delete();
    if (ended) return;
    if (at_end || c == CH_EOF) begin
      // an open comment just ends; a dangling backslash is dropped
      if (mode == SCAN_RUN) close_run();
      else if (mode == SCAN_STRING || mode == SCAN_ESCAPE) close_string();
      mode = SCAN_IDLE;
      add_beat(KIND_END, '0, '0, 1'b0);
      ended = 1'b1;
    end else if (c == CH_CR || c == CH_NUL) begin
      return;
    end else begin
      case (mode)
        SCAN_COMMENT: if (c == CH_LF) mode = SCAN_IDLE;
        SCAN_STRING: begin
          if (c == CH_QUOTE) close_string();
          else if (is_blank(c)) space_owed = 1'b1;
          else if (c == CH_BSLASH) mode = SCAN_ESCAPE;
          else begin
            flush_space();
            put_str_byte(c);
          end
        end
        SCAN_ESCAPE: begin
          if (c == CH_LN) c = CH_LF;
          else if (c == CH_LT) c = CH_TAB;
          flush_space();
          put_str_byte(c);
          mode = SCAN_STRING;
        end
        SCAN_RUN: begin
          if (is_blank(c) || c == CH_LPAREN || c == CH_RPAREN || c == CH_QUOTE) begin
            close_run();
            idle_char(c);
          end else begin
            run_char(c, 1'b0);
          end
        end
        default: begin
          mode = SCAN_IDLE;
          idle_char(c);
        end
      endcase
    end
    if (step_beats.size() > 0) begin
      t = step_beats.pop_back();
      t.last = 1'b1;
      step_beats.push_back(t);
    end
  endfunction

  function automatic int unsigned draw_gap(input bit paced);
    return paced ? $urandom_range(0, 12) : 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Character driver: offers queued characters, idles between beats when
  // paced, and feeds each accepted beat to the shadow scanner.
  // ---------------------------------------------------------------------------
  int unsigned src_gap = 0;
  src_char_t   next_char;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        scan_char(s_tdata, s_tlast);
        while (step_beats.size() > 0) pending_tokens.push_back(step_beats.pop_front());
        src_gap = draw_gap(src_paced);
      end
      if (s_tvalid && !s_tready) begin
        // beat still on offer, hold it
      end else if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_chars.size() > 0) begin
        next_char = pending_chars.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_char.ch;
        s_tlast  <= next_char.at_end;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and sink. Every beat is matched against the oldest
  // expectation. Twice in the run the sink holds off for a long stretch so
  // the command queue fills and the scanner pushes back on its input.
  // ---------------------------------------------------------------------------
  int unsigned sink_gap    = 0;
  int unsigned sink_hold   = 0;
  int unsigned beats_taken = 0;
  token_beat_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_tokens.size() == 0) begin
          $error("unexpected result beat: kind %0d value %0d", m_tuser, $signed(m_tdata[39:8]));
          mismatches++;
        end else begin
          want = pending_tokens.pop_front();
          if (m_tuser !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, m_tuser);
            mismatches++;
          end
          if (m_tdata[7:0] !== want.data_byte) begin
            $error("data_byte: expected 0x%02h, got 0x%02h", want.data_byte, m_tdata[7:0]);
            mismatches++;
          end
          if (m_tdata[39:8] !== want.value) begin
            $error("value: expected %0d, got %0d", $signed(want.value),
                   $signed(m_tdata[39:8]));
            mismatches++;
          end
          if (m_tdata[40] !== want.truncated) begin
            $error("truncated: expected %0b, got %0b", want.truncated, m_tdata[40]);
            mismatches++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_tlast);
            mismatches++;
          end
        end
        beats_taken++;
        if (beats_taken == 40 || beats_taken == 200) sink_hold = 160;
        sink_gap = draw_gap(sink_paced);
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when nothing moves on any channel for too long.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("source_text_token_scanner verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void feed(input logic [7:0] c, input logic at_end);
    src_char_t s;
    s.ch     = c;
    s.at_end = at_end;
    pending_chars.push_back(s);
  endfunction

  function automatic void feed_text(input string s);
    for (int i = 0; i < s.len(); i++) feed(s[i], 1'b0);
  endfunction

  // Any byte that keeps a run going (no delimiter, nothing dropped, no end).
  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do begin
      case ($urandom_range(0, 3))
        0: c = 8'($urandom_range(CH_UA, CH_UZ));
        1: c = 8'($urandom_range(8'h61, 8'h7A));
        2: c = 8'($urandom_range(CH_0, CH_9));
        default: c = 8'($urandom_range(0, 255));
      endcase
    end while (is_blank(c) || c == CH_LPAREN || c == CH_RPAREN || c == CH_QUOTE ||
               c == CH_NUL || c == CH_EOF);
    return c;
  endfunction

  function automatic logic [7:0] any_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_EOF);
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 4))
      0: return CH_TAB;
      1: return CH_LF;
      2: return CH_VT;
      3: return CH_FF;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic void random_word();
    int n;
    n = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
    repeat (n) feed(word_char(), 1'b0);
    case ($urandom_range(0, 4))
      0: feed(CH_LPAREN, 1'b0);
      1: feed(CH_RPAREN, 1'b0);
      2: ;  // left open, the next fragment may extend it
      default: feed(blank_char(), 1'b0);
    endcase
  endfunction

  function automatic void random_number();
    string limit_numbers[4] = '{"2147483647", "2147483648", "-2147483648", "-2147483649"};
    int    n;
    if ($urandom_range(0, 7) == 0) begin
      feed_text(limit_numbers[$urandom_range(0, 3)]);
    end else begin
      case ($urandom_range(0, 2))
        1: feed(CH_PLUS, 1'b0);
        2: feed(CH_MINUS, 1'b0);
        default: ;
      endcase
      case ($urandom_range(0, 19))
        0: n = 0;                           // bare sign
        1: n = $urandom_range(66, 70);      // truncated number
        2, 3, 4, 5, 6: n = $urandom_range(9, 12);
        default: n = $urandom_range(1, 5);
      endcase
      repeat (n) feed(8'($urandom_range(CH_0, CH_9)), 1'b0);
      if ($urandom_range(0, 5) == 0) feed(word_char(), 1'b0);
    end
    feed(($urandom_range(0, 3) == 0) ? CH_RPAREN : blank_char(), 1'b0);
  endfunction

  function automatic void random_string();
    feed(CH_QUOTE, 1'b0);
    repeat ($urandom_range(0, 10)) begin
      case ($urandom_range(0, 7))
        0, 1, 2: feed(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
        3: feed(any_byte(), 1'b0);
        4: repeat ($urandom_range(1, 3)) feed(blank_char(), 1'b0);
        5: begin
          feed(CH_BSLASH, 1'b0);
          case ($urandom_range(0, 5))
            0: feed(CH_LN, 1'b0);
            1: feed(CH_LT, 1'b0);
            2: feed(CH_QUOTE, 1'b0);
            3: feed(CH_BSLASH, 1'b0);
            4: feed(blank_char(), 1'b0);
            default: feed(any_byte(), 1'b0);
          endcase
        end
        6: feed(($urandom_range(0, 1) == 0) ? CH_CR : CH_NUL, 1'b0);
        default: feed(CH_SPACE, 1'b0);
      endcase
    end
    feed(CH_QUOTE, 1'b0);
  endfunction

  function automatic void random_comment();
    logic [7:0] c;
    feed(CH_SEMI, 1'b0);
    repeat ($urandom_range(0, 4)) begin
      c = any_byte();
      feed((c == CH_LF) ? CH_SPACE : c, 1'b0);
    end
    feed(CH_LF, 1'b0);
  endfunction

  // Mostly well-formed tokens with random content, some noise in between.
  function automatic void random_text(input int n);
    int base;
    base = pending_chars.size();
    while (pending_chars.size() - base < n) begin
      case ($urandom_range(0, 11))
        0, 1: feed(($urandom_range(0, 1) == 0) ? CH_LPAREN : CH_RPAREN, 1'b0);
        2, 3: random_word();
        4, 5: random_number();
        6, 7, 8: random_string();
        9: random_comment();
        10: feed(blank_char(), 1'b0);
        default: feed(any_byte(), 1'b0);
      endcase
    end
  endfunction

  task automatic write_start_offset(input logic [OFFSET_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    msg_offset = v;
    cfg_valid <= 1'b0;
  endtask

  // Block is idle once everything is sent and answered; characters that
  // cause no result may still be in the pipe, so give them time to drain.
  task automatic wait_idle();
    while (pending_chars.size() != 0 || s_tvalid || pending_tokens.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Phase 1: directed text, no idling on either side, offset zero.
    write_start_offset('0);
    @(negedge clk);
    // open, uppercase run with an inner minus, close, negative zero
    feed_text("(Q-9)-0 ");
    // string: leading whitespace, dropped CR and NUL, newline escape,
    // escaped quote, trailing whitespace before the terminator
    feed_text("\" ");
    feed(CH_CR, 1'b0);
    feed_text("a\\n");
    feed(CH_NUL, 1'b0);
    feed_text("\\\"\t\"");
    // comment to newline, signed number, close
    feed_text(";x\n+7)");
    random_text(RANDOM_ITEMS / 4);
    wait_idle();

    // Phase 2: offset near the top so string words saturate it.
    src_paced  <= 1'b1;
    sink_paced <= 1'b1;
    write_start_offset(24'hFFFFFD);
    @(negedge clk);
    random_text(RANDOM_ITEMS / 4);
    wait_idle();

    // Phase 3: random offset, fast source against a slow sink.
    src_paced  <= 1'b0;
    sink_paced <= 1'b1;
    write_start_offset(24'($urandom_range(0, 24'hFFFFFF)));
    @(negedge clk);
    random_text(RANDOM_ITEMS / 4);
    wait_idle();

    // Phase 4: offset at its maximum, then end of input in some open state.
    src_paced  <= 1'b1;
    sink_paced <= 1'b0;
    write_start_offset(24'hFFFFFF);
    @(negedge clk);
    random_text(RANDOM_ITEMS / 4);
    case ($urandom_range(0, 3))
      0: feed_text(" \"ab \\");  // string with owed space and dangling backslash
      1: feed_text(" Xy12");     // open run
      2: feed_text(" ;zz");      // open comment
      default: feed(CH_RPAREN, 1'b0);
    endcase
    if ($urandom_range(0, 1) == 0) feed(8'($urandom_range(0, 255)), 1'b1);
    else feed(CH_EOF, 1'b0);
    // everything after the end marker is taken and ignored
    feed(CH_LPAREN, 1'b1);
    feed(CH_EOF, 1'b0);
    repeat (4) feed(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    wait_idle();

    if (mismatches == 0) begin
      $display("source_text_token_scanner verification clean");
    end else begin
      $display("source_text_token_scanner verification failed");
    end
    $finish;
  end

endmodule

[source_text_token_scanner.f]
design/sts_pkg.sv
design/sts_front.sv
design/sts_queue.sv
design/sts_back.sv
design/source_text_token_scanner.sv
test/tb.sv
